// ===== rtl/core/polyline_densify_interpolate_defines.svh =====
// Assertion macros shared by the checker of polyline_densify_interpolate.
// No dependencies.
`ifndef POLYLINE_DENSIFY_INTERPOLATE_DEFINES_SVH
`define POLYLINE_DENSIFY_INTERPOLATE_DEFINES_SVH

// a holds at an edge, so b holds at the next edge
`define PDI_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("label failed");

// a implies b at the same edge
`define PDI_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("label failed");

`endif

// ===== rtl/core/pdi_pkg.sv =====
// Shared constants and types for the polyline densifier.
// No dependencies.
`timescale 1ns / 1ps
package pdi_pkg;
  localparam int CoordW       = 24;
  localparam int SpacingW     = 16;
  localparam int MaxInserted  = 63;
  localparam logic [SpacingW-1:0] SpacingReset = 16'd1280;
  localparam int RootSteps    = 25;   // 2 radicand bits per step, 50-bit radicand
  localparam int QuoBits      = 25;   // quotient magnitude stays below 2**24 + 1
  typedef logic signed [CoordW-1:0] coord_t;
endpackage

// ===== rtl/core/pdi_stream_if.sv =====
// Valid/ready request channels for waypoints and emitted points.
// Depends on pdi_pkg.
`timescale 1ns / 1ps
interface pdi_point_if;
  import pdi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   path_start;
  modport source (output valid, point_x, point_y, path_start, input ready);
  modport sink   (input valid, point_x, point_y, path_start, output ready);
endinterface

interface pdi_result_if;
  import pdi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  logic   is_inserted;
  logic   capped;
  logic   last_of_run;
  modport source (output valid, out_x, out_y, is_inserted, capped, last_of_run,
                  input ready);
  modport sink   (input valid, out_x, out_y, is_inserted, capped, last_of_run,
                  output ready);
endinterface

// ===== rtl/core/polyline_densify_interpolate.sv =====
// Polyline densifier top level: serial square root and dividers, output register.
// Depends on pdi_pkg and the channel interfaces in pdi_stream_if.sv.
`timescale 1ns / 1ps
// One waypoint request at a time. The first point of a path is passed straight
// to the output register. A segment that needs no split goes through the squares
// and the compare, then emits the waypoint. A split segment runs a 25-step
// bit-serial square root up front, and for every inserted point the two 25-step
// bit-serial dividers that scale x and y; each result may wait on output stalls.
// Points are emitted in order and the waypoint comes last with last_of_run set.
// A spacing of 0 acts as 1.
module polyline_densify_interpolate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pdi_pkg::SpacingW-1:0]  cfg_wr_data,
  pdi_point_if.sink                     points,
  pdi_result_if.source                  results
);
  import pdi_pkg::*;

  typedef enum logic [3:0] {
    IDLE, SQUARE, SUM, CHECK, ROOT, DIST, PMUL, PCHK, DIVIDE, EMIT, WAIT_PT,
    WAIT_LAST
  } state_t;

  state_t               state;
  logic [SpacingW-1:0]  spacing;
  logic [SpacingW-1:0]  s_eff;
  coord_t               prev_x, prev_y, cur_x, cur_y;
  logic                 have_prev;
  logic signed [24:0]   dx, dy;
  logic [48:0]          sqx, sqy;
  logic [49:0]          d2;
  logic [31:0]          ss;
  logic [21:0]          s63;
  logic [43:0]          s63sq;
  logic                 cap;
  logic [49:0]          rad;
  logic [24:0]          root;
  logic [26:0]          srem;
  logic [4:0]           cnt;
  logic [25:0]          seg_len;
  logic [6:0]           k;
  logic [21:0]          ks;
  logic [43:0]          kss;
  logic [46:0]          numx, numy;
  logic [24:0]          nx, ny;
  logic [26:0]          rx, ry;
  logic [24:0]          qx, qy;

  logic signed [24:0]   dx_next, dy_next;
  logic signed [49:0]   prodx, prody;
  logic [24:0]          absx, absy;
  logic [28:0]          sq_shift;
  logic [26:0]          sq_trial;
  logic [48:0]          nnx, nny;
  logic [26:0]          dd;
  logic [27:0]          tx, ty;
  logic [25:0]          ox, oy;

  assign s_eff   = (spacing == '0) ? SpacingW'(1) : spacing;
  assign dx_next = 25'($signed(points.point_x)) - 25'($signed(prev_x));
  assign dy_next = 25'($signed(points.point_y)) - 25'($signed(prev_y));
  assign prodx   = dx * dx;
  assign prody   = dy * dy;
  assign absx    = dx[24] ? 25'(-dx) : 25'(dx);
  assign absy    = dy[24] ? 25'(-dy) : 25'(dy);
  assign sq_shift = {srem, rad[49:48]};
  assign sq_trial = {root, 2'b01};
  // round half away from zero: (2*mag + seg_len) / (2*seg_len)
  assign nnx = {1'b0, numx, 1'b0} + 49'(seg_len);
  assign nny = {1'b0, numy, 1'b0} + 49'(seg_len);
  assign dd  = {seg_len, 1'b0};
  assign tx  = {rx, nx[24]};
  assign ty  = {ry, ny[24]};
  assign ox  = dx[24] ? 26'(-{1'b0, qx}) : {1'b0, qx};
  assign oy  = dy[24] ? 26'(-{1'b0, qy}) : {1'b0, qy};

  assign points.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      spacing       <= SpacingReset;
      have_prev     <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        spacing <= cfg_wr_data;
      end
      case (state)
        IDLE: begin
          if (points.valid) begin
            cur_x <= points.point_x;
            cur_y <= points.point_y;
            if (points.path_start || !have_prev) begin
              results.out_x       <= points.point_x;
              results.out_y       <= points.point_y;
              results.is_inserted <= 1'b0;
              results.capped      <= 1'b0;
              results.last_of_run <= 1'b1;
              results.valid       <= 1'b1;
              prev_x              <= points.point_x;
              prev_y              <= points.point_y;
              have_prev           <= 1'b1;
              state               <= WAIT_LAST;
            end else begin
              dx    <= dx_next;
              dy    <= dy_next;
              state <= SQUARE;
            end
          end
        end
        SQUARE: begin
          sqx   <= prodx[48:0];
          sqy   <= prody[48:0];
          ss    <= s_eff * s_eff;
          s63   <= 22'(s_eff) * 22'(MaxInserted);
          state <= SUM;
        end
        SUM: begin
          d2    <= 50'(sqx) + 50'(sqy);
          s63sq <= s63 * s63;
          state <= CHECK;
        end
        CHECK: begin
          // the cap implies a split, since (63*s)^2 >= s^2
          cap <= (50'(s63sq) < d2);
          if (d2 > 50'(ss)) begin
            rad   <= d2;
            root  <= '0;
            srem  <= '0;
            cnt   <= '0;
            k     <= 7'd1;
            ks    <= 22'(s_eff);
            state <= ROOT;
          end else begin
            state <= EMIT;
          end
        end
        ROOT: begin
          if (sq_shift >= 29'(sq_trial)) begin
            srem <= 27'(sq_shift - 29'(sq_trial));
            root <= {root[23:0], 1'b1};
          end else begin
            srem <= sq_shift[26:0];
            root <= {root[23:0], 1'b0};
          end
          rad <= {rad[47:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(RootSteps - 1)) begin
            state <= DIST;
          end
        end
        DIST: begin
          seg_len <= (srem > 27'(root)) ? 26'(root) + 26'd1 : 26'(root);
          state   <= PMUL;
        end
        PMUL: begin
          kss   <= ks * ks;
          numx  <= ks * absx;
          numy  <= ks * absy;
          state <= PCHK;
        end
        PCHK: begin
          if (k > 7'(MaxInserted) || 50'(kss) >= d2) begin
            state <= EMIT;
          end else begin
            rx    <= 27'(nnx[48:25]);
            ry    <= 27'(nny[48:25]);
            nx    <= nnx[24:0];
            ny    <= nny[24:0];
            cnt   <= '0;
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (tx >= 28'(dd)) begin
            rx <= 27'(tx - 28'(dd));
            qx <= {qx[23:0], 1'b1};
          end else begin
            rx <= tx[26:0];
            qx <= {qx[23:0], 1'b0};
          end
          if (ty >= 28'(dd)) begin
            ry <= 27'(ty - 28'(dd));
            qy <= {qy[23:0], 1'b1};
          end else begin
            ry <= ty[26:0];
            qy <= {qy[23:0], 1'b0};
          end
          nx  <= {nx[23:0], 1'b0};
          ny  <= {ny[23:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QuoBits - 1)) begin
            state <= WAIT_PT;
          end
        end
        WAIT_PT: begin
          // first cycle here loads the point, then hold until taken
          if (!results.valid) begin
            results.out_x       <= 24'(26'($signed(prev_x)) + ox);
            results.out_y       <= 24'(26'($signed(prev_y)) + oy);
            results.is_inserted <= 1'b1;
            results.capped      <= cap;
            results.last_of_run <= 1'b0;
            results.valid       <= 1'b1;
          end else if (results.ready) begin
            results.valid <= 1'b0;
            k             <= k + 7'd1;
            ks            <= ks + 22'(s_eff);
            state         <= PMUL;
          end
        end
        EMIT: begin
          results.out_x       <= cur_x;
          results.out_y       <= cur_y;
          results.is_inserted <= 1'b0;
          results.capped      <= cap;
          results.last_of_run <= 1'b1;
          results.valid       <= 1'b1;
          prev_x              <= cur_x;
          prev_y              <= cur_y;
          have_prev           <= 1'b1;
          state               <= WAIT_LAST;
        end
        WAIT_LAST: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/pdi_checker.sv =====
// Port-level checks for polyline_densify_interpolate, bound to the top level.
// Depends on polyline_densify_interpolate_defines.svh.
`timescale 1ns / 1ps
`include "polyline_densify_interpolate_defines.svh"
module pdi_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  // a stalled result stays offered
  `PDI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // one request at a time
  `PDI_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  // more results follow a non-final one, so no new request yet
  `PDI_ASSERT_NEXT(a_run_open, clk, rst, out_valid && out_ready && !out_last, !in_ready)
  // ready for a request only once every result is gone
  `PDI_ASSERT_NOW(a_drained, clk, rst, in_ready, !out_valid)
endmodule

bind polyline_densify_interpolate pdi_checker u_pdi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (points.valid),
  .in_ready  (points.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_last  (results.last_of_run)
);
